@@ src/yuv2rgb_pkg.sv @@
// Package for the YCbCr to RGB converter: pixel types, mode codes, coefficient helper.
`default_nettype none

package yuv2rgb_pkg;

    // Default fixed-point precision of the conversion coefficients
    localparam int COEFF_FRAC_BITS_DEF = 14;

    // Conversion mode codes (any other code behaves as BT.601 full range)
    localparam logic [1:0] MODE_BT601_FULL    = 2'd0;
    localparam logic [1:0] MODE_BT709_FULL    = 2'd1;
    localparam logic [1:0] MODE_BT709_LIMITED = 2'd2;

    // Coefficients in millionths
    localparam longint unsigned K601_RV = 64'd1402000;
    localparam longint unsigned K601_GU = 64'd344136;
    localparam longint unsigned K601_GV = 64'd714136;
    localparam longint unsigned K601_BU = 64'd1772000;
    localparam longint unsigned K709_RV = 64'd1574800;
    localparam longint unsigned K709_GU = 64'd187300;
    localparam longint unsigned K709_GV = 64'd468100;
    localparam longint unsigned K709_BU = 64'd1855600;
    localparam longint unsigned KLIM_Y  = 64'd1164400;
    localparam longint unsigned KLIM_RV = 64'd1792700;
    localparam longint unsigned KLIM_GU = 64'd213200;
    localparam longint unsigned KLIM_GV = 64'd532900;
    localparam longint unsigned KLIM_BU = 64'd2112400;

    localparam longint unsigned MILLION = 64'd1000000;
    localparam longint unsigned HALF_MILLION = 64'd500000;

    // Input transaction: one luma sample and its shared chroma pair
    typedef struct packed {
        logic [9:0] luma;
        logic [9:0] blue_diff;
        logic [9:0] red_diff;
    } t_yuv_pixel;

    // Output transaction: one RGB pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_pixel;

    // Millionths to fixed point with frac_bits fractional bits, rounded to nearest
    function automatic longint unsigned fix_coeff(input longint unsigned k,
                                                  input int frac_bits);
        return ((k << frac_bits) + HALF_MILLION) / MILLION;
    endfunction

endpackage

`default_nettype wire

@@ src/yuv_to_rgb_color_converter_unit.sv @@
// Top level: four-stage pipelined YCbCr to RGB converter (BT.601 / BT.709).
// o_valid follows an accepted start through the r_v1..r_v4 stage valid registers.
// Throughput: one pixel per cycle while busy is low; the four register stages (decode,
// multiply, sum, floor/saturate) each take a new pixel every clock.
// busy is high only while reset is held and drops in the cycle after release.
// Reset clears the stage valid bits and sets the mode register to BT.601 full.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module yuv_to_rgb_color_converter_unit
    import yuv2rgb_pkg::*;
#(
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       start,
    output logic            busy,
    input  wire t_yuv_pixel i_pixel,
    output logic            o_valid,
    output t_rgb_pixel      o_pixel
);

    // Widths: coefficient, offset sample, product, sum
    localparam int CW = COEFF_FRAC_BITS + 4;
    localparam int SMW = 11;
    localparam int PW = CW + SMW;
    localparam int SW = PW + 2;
    localparam int SH_FULL = COEFF_FRAC_BITS;
    localparam int SH_LIM = COEFF_FRAC_BITS + 2;

    localparam logic signed [CW-1:0] C_ONE = CW'(64'd1 << COEFF_FRAC_BITS);
    localparam logic signed [CW-1:0] C601_RV = CW'(fix_coeff(K601_RV, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] C601_GU = CW'(fix_coeff(K601_GU, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] C601_GV = CW'(fix_coeff(K601_GV, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] C601_BU = CW'(fix_coeff(K601_BU, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] C709_RV = CW'(fix_coeff(K709_RV, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] C709_GU = CW'(fix_coeff(K709_GU, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] C709_GV = CW'(fix_coeff(K709_GV, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] C709_BU = CW'(fix_coeff(K709_BU, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] CLIM_Y  = CW'(fix_coeff(KLIM_Y,  COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] CLIM_RV = CW'(fix_coeff(KLIM_RV, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] CLIM_GU = CW'(fix_coeff(KLIM_GU, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] CLIM_GV = CW'(fix_coeff(KLIM_GV, COEFF_FRAC_BITS));
    localparam logic signed [CW-1:0] CLIM_BU = CW'(fix_coeff(KLIM_BU, COEFF_FRAC_BITS));

    // Control registers
    logic [1:0] r_mode;
    logic       r_busy;
    logic       r_v1, r_v2, r_v3, r_v4;
    logic       r_lim1, r_lim2, r_lim3;

    // Stage 1 payload: offset-removed samples and selected coefficients
    logic signed [SMW-1:0] r_y, r_u, r_v;
    logic signed [CW-1:0]  r_cy, r_crv, r_cgu, r_cgv, r_cbu;
    logic signed [SMW-1:0] n_y, n_u, n_v;
    logic signed [CW-1:0]  n_cy, n_crv, n_cgu, n_cgv, n_cbu;
    logic                  n_lim;

    // Stage 2 payload: products
    logic signed [PW-1:0] r_py, r_prv, r_pgu, r_pgv, r_pbu;

    // Stage 3 payload: sums
    logic signed [SW-1:0] r_rs, r_gs, r_bs;

    // Stage 4: output pixel
    t_rgb_pixel r_pix;
    t_rgb_pixel n_pix;

    logic accept;
    assign accept = start && !r_busy;

    // Mode register and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BT601_FULL;
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Stage 1 decode: sample offsets and coefficient set by mode
    always_comb begin
        n_y = SMW'({3'b000, i_pixel.luma[7:0]});
        n_u = SMW'({3'b000, i_pixel.blue_diff[7:0]}) - SMW'(128);
        n_v = SMW'({3'b000, i_pixel.red_diff[7:0]}) - SMW'(128);
        n_cy = C_ONE;
        n_crv = C601_RV;
        n_cgu = C601_GU;
        n_cgv = C601_GV;
        n_cbu = C601_BU;
        n_lim = 1'b0;
        case (r_mode)
            MODE_BT709_FULL: begin
                n_crv = C709_RV;
                n_cgu = C709_GU;
                n_cgv = C709_GV;
                n_cbu = C709_BU;
            end
            MODE_BT709_LIMITED: begin
                n_y = SMW'({1'b0, i_pixel.luma}) - SMW'(64);
                n_u = SMW'({1'b0, i_pixel.blue_diff}) - SMW'(512);
                n_v = SMW'({1'b0, i_pixel.red_diff}) - SMW'(512);
                n_cy = CLIM_Y;
                n_crv = CLIM_RV;
                n_cgu = CLIM_GU;
                n_cgv = CLIM_GV;
                n_cbu = CLIM_BU;
                n_lim = 1'b1;
            end
            default: begin
                n_lim = 1'b0;
            end
        endcase
    end

    // Pipeline payload registers
    always_ff @(posedge i_clk) begin
        // stage 1
        r_y <= n_y;
        r_u <= n_u;
        r_v <= n_v;
        r_cy <= n_cy;
        r_crv <= n_crv;
        r_cgu <= n_cgu;
        r_cgv <= n_cgv;
        r_cbu <= n_cbu;
        r_lim1 <= n_lim;
        // stage 2: one multiplier per term, operands sign-extended to product width
        r_py <= PW'(r_cy) * PW'(r_y);
        r_prv <= PW'(r_crv) * PW'(r_v);
        r_pgu <= PW'(r_cgu) * PW'(r_u);
        r_pgv <= PW'(r_cgv) * PW'(r_v);
        r_pbu <= PW'(r_cbu) * PW'(r_u);
        r_lim2 <= r_lim1;
        // stage 3: sums
        r_rs <= SW'(r_py) + SW'(r_prv);
        r_gs <= SW'(r_py) - SW'(r_pgu) - SW'(r_pgv);
        r_bs <= SW'(r_py) + SW'(r_pbu);
        r_lim3 <= r_lim2;
        // stage 4
        r_pix <= n_pix;
    end

    // Floor by the fixed-point shift, then clamp to 0..255
    function automatic logic [7:0] sat_floor(input logic signed [SW-1:0] sum,
                                             input logic lim);
        logic signed [SW-1:0] q;
        q = lim ? (sum >>> SH_LIM) : (sum >>> SH_FULL);
        if (q < 0) begin
            return 8'd0;
        end else if (q > 255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

    always_comb begin
        n_pix.red = sat_floor(r_rs, r_lim3);
        n_pix.green = sat_floor(r_gs, r_lim3);
        n_pix.blue = sat_floor(r_bs, r_lim3);
    end

    assign busy = r_busy;
    assign o_valid = r_v4;
    assign o_pixel = r_pix;

endmodule

`default_nettype wire
